// ----- rtl/core/tpcd_pkg.sv -----
// tpcd_pkg: shared constants, types and state codes for the trie prefix
// conflict detector. No dependencies; used by tpcd_in_if, tpcd_walker and the top level.

package tpcd_pkg;

  // node pool size and trie fan-out
  localparam int unsigned NODE_COUNT = 4096;
  localparam int unsigned FANOUT     = 10;

  // derived widths
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W     = NODE_W + 1;
  localparam int unsigned SLOT_COUNT = NODE_COUNT * FANOUT;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned DIGIT_W    = 4;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // one request item
  typedef struct packed {
    logic               cmd;
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
  } item_t;

  // one result item
  typedef struct packed {
    logic conflict;
    logic overflow;
    logic word_done;
  } res_t;

  // per-node entry of the node memory
  typedef struct packed {
    logic [FANOUT-1:0] mask;
    logic              end_mark;
  } node_t;

  // port bundle of the child-slot memory
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [NODE_W-1:0] wr_data;
  } child_req_t;

  // port bundle of the node memory
  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    node_t             wr_data;
  } node_req_t;

  // walker states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_NODE,
    ST_ALLOC
  } state_e;

endpackage

// ----- rtl/core/tpcd_in_if.sv -----
// tpcd_in_if: request channel of the trie prefix conflict detector.
// Depends on tpcd_pkg for the digit width.

interface tpcd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [tpcd_pkg::DIGIT_W-1:0] digit;
  logic                        last_digit;

  modport source (output valid, cmd, digit, last_digit, input ready);
  modport sink   (input valid, cmd, digit, last_digit, output ready);
endinterface

// ----- rtl/core/tpcd_out_if.sv -----
// tpcd_out_if: result channel of the trie prefix conflict detector.
// No package dependencies.

interface tpcd_out_if;
  logic valid;
  logic ready;
  logic conflict;
  logic overflow;
  logic word_done;

  modport source (output valid, conflict, overflow, word_done, input ready);
  modport sink   (input valid, conflict, overflow, word_done, output ready);
endinterface

// ----- rtl/core/tpcd_ram.sv -----
// tpcd_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No package dependencies.

module tpcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/tpcd_walker.sv -----
// tpcd_walker: sequencer that walks and grows the trie, one digit per request,
// by read-modify-write of the child-slot and node memories.
// Depends on tpcd_pkg.

module tpcd_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tpcd_pkg::item_t               in_item_i,
  output tpcd_pkg::child_req_t          child_req_o,
  input  logic [tpcd_pkg::NODE_W-1:0]   child_rd_data_i,
  output tpcd_pkg::node_req_t           node_req_o,
  input  tpcd_pkg::node_t               node_rd_data_i,
  input  logic                          res_free_i,
  output logic                          res_load_o,
  output tpcd_pkg::res_t                res_o
);

  tpcd_pkg::state_e                 state_q, state_d;
  tpcd_pkg::item_t                  item_q, item_d;
  logic [tpcd_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic [tpcd_pkg::NODE_W-1:0]      cursor_q, cursor_d;
  logic [tpcd_pkg::NODE_W-1:0]      nxt_q, nxt_d;
  logic [tpcd_pkg::FANOUT-1:0]      cur_mask_q, cur_mask_d;
  logic                             cur_end_q, cur_end_d;
  logic [tpcd_pkg::FANOUT-1:0]      root_mask_q, root_mask_d;
  logic [tpcd_pkg::FREE_W-1:0]      nfree_q, nfree_d;
  logic                             conflict_q, conflict_d;
  logic                             overflow_q, overflow_d;
  logic                             skip_q, skip_d;

  logic                             accept;
  logic                             digit_ok;
  logic                             at_root;
  logic [tpcd_pkg::FANOUT-1:0]      cur_mask;
  logic                             cur_end;
  logic                             hit;
  logic                             pool_full;
  logic                             look_fin;
  logic [tpcd_pkg::SLOT_W-1:0]      slot_calc;
  logic [tpcd_pkg::FANOUT-1:0]      mask_set;

  // shared decode
  assign accept    = in_valid_i && (state_q == tpcd_pkg::ST_IDLE);
  assign digit_ok  = item_q.digit < tpcd_pkg::DIGIT_W'(tpcd_pkg::FANOUT);
  assign at_root   = (cursor_q == '0);
  assign cur_mask  = at_root ? root_mask_q : cur_mask_q;
  assign cur_end   = at_root ? 1'b0 : cur_end_q;
  assign hit       = digit_ok && cur_mask[item_q.digit];
  assign pool_full = (nfree_q == tpcd_pkg::FREE_W'(tpcd_pkg::NODE_COUNT));
  assign look_fin  = (item_q.cmd == tpcd_pkg::CMD_CLEAR) || !digit_ok || skip_q ||
                     (!hit && pool_full);
  assign mask_set  = cur_mask | (tpcd_pkg::FANOUT'(1) << item_q.digit);

  // child slot = cursor * 10 + digit
  assign slot_calc = (tpcd_pkg::SLOT_W'(cursor_q) << 3) + (tpcd_pkg::SLOT_W'(cursor_q) << 1) +
                     tpcd_pkg::SLOT_W'(in_item_i.digit);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tpcd_pkg::ST_LOOK;
        end
      end
      tpcd_pkg::ST_LOOK: begin
        if (look_fin) begin
          if (res_free_i) begin
            state_d = tpcd_pkg::ST_IDLE;
          end
        end else if (hit) begin
          state_d = tpcd_pkg::ST_NODE;
        end else begin
          state_d = tpcd_pkg::ST_ALLOC;
        end
      end
      tpcd_pkg::ST_NODE, tpcd_pkg::ST_ALLOC: begin
        if (res_free_i) begin
          state_d = tpcd_pkg::ST_IDLE;
        end
      end
      default: state_d = tpcd_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory accesses per state
  always_comb begin
    item_d      = item_q;
    slot_d      = slot_q;
    cursor_d    = cursor_q;
    nxt_d       = nxt_q;
    cur_mask_d  = cur_mask_q;
    cur_end_d   = cur_end_q;
    root_mask_d = root_mask_q;
    nfree_d     = nfree_q;
    conflict_d  = conflict_q;
    overflow_d  = overflow_q;
    skip_d      = skip_q;
    child_req_o = '0;
    node_req_o  = '0;
    res_load_o  = 1'b0;
    res_o       = '0;
    in_ready_o  = (state_q == tpcd_pkg::ST_IDLE);

    case (state_q)
      tpcd_pkg::ST_IDLE: begin
        // latch the request and fetch its child slot
        if (accept) begin
          item_d              = in_item_i;
          slot_d              = slot_calc;
          child_req_o.rd_en   = (in_item_i.cmd == tpcd_pkg::CMD_INSERT) && !skip_q &&
                                (in_item_i.digit < tpcd_pkg::DIGIT_W'(tpcd_pkg::FANOUT));
          child_req_o.rd_addr = slot_calc;
        end
      end

      tpcd_pkg::ST_LOOK: begin
        if (look_fin) begin
          // requests that finish here: clear, bad digit, dropped digit, no free node
          if (res_free_i) begin
            res_load_o = 1'b1;
            if (item_q.cmd == tpcd_pkg::CMD_CLEAR) begin
              root_mask_d = '0;
              cursor_d    = '0;
              nfree_d     = tpcd_pkg::FREE_W'(1);
              conflict_d  = 1'b0;
              overflow_d  = 1'b0;
              skip_d      = 1'b0;
            end else if (!digit_ok) begin
              res_o.word_done = 1'b0;
            end else if (skip_q) begin
              if (item_q.last_digit) begin
                skip_d          = 1'b0;
                cursor_d        = '0;
                res_o.word_done = 1'b1;
              end
            end else begin
              overflow_d = 1'b1;
              if (item_q.last_digit) begin
                cursor_d        = '0;
                res_o.word_done = 1'b1;
              end else begin
                skip_d = 1'b1;
              end
            end
            res_o.conflict = conflict_d;
            res_o.overflow = overflow_d;
          end
        end else if (hit) begin
          // existing child: fetch its node entry
          nxt_d              = child_rd_data_i;
          node_req_o.rd_en   = 1'b1;
          node_req_o.rd_addr = child_rd_data_i;
        end else begin
          // new child: link it and mark it in the current node
          nxt_d               = nfree_q[tpcd_pkg::NODE_W-1:0];
          nfree_d             = nfree_q + tpcd_pkg::FREE_W'(1);
          child_req_o.wr_en   = 1'b1;
          child_req_o.wr_addr = slot_q;
          child_req_o.wr_data = nfree_q[tpcd_pkg::NODE_W-1:0];
          if (at_root) begin
            root_mask_d = mask_set;
          end else begin
            cur_mask_d                  = mask_set;
            node_req_o.wr_en            = 1'b1;
            node_req_o.wr_addr          = cursor_q;
            node_req_o.wr_data.mask     = mask_set;
            node_req_o.wr_data.end_mark = cur_end;
          end
        end
      end

      tpcd_pkg::ST_NODE: begin
        // step into an existing node
        if (res_free_i) begin
          res_load_o = 1'b1;
          if (node_rd_data_i.end_mark) begin
            conflict_d = 1'b1;
          end
          if (item_q.last_digit) begin
            if (node_rd_data_i.mask != '0) begin
              conflict_d = 1'b1;
            end
            node_req_o.wr_en            = 1'b1;
            node_req_o.wr_addr          = nxt_q;
            node_req_o.wr_data.mask     = node_rd_data_i.mask;
            node_req_o.wr_data.end_mark = 1'b1;
            cursor_d                    = '0;
            res_o.word_done             = 1'b1;
          end else begin
            cursor_d   = nxt_q;
            cur_mask_d = node_rd_data_i.mask;
            cur_end_d  = node_rd_data_i.end_mark;
          end
          res_o.conflict = conflict_d;
          res_o.overflow = overflow_d;
        end
      end

      tpcd_pkg::ST_ALLOC: begin
        // initialize the fresh node
        if (res_free_i) begin
          res_load_o                  = 1'b1;
          node_req_o.wr_en            = 1'b1;
          node_req_o.wr_addr          = nxt_q;
          node_req_o.wr_data.mask     = '0;
          node_req_o.wr_data.end_mark = item_q.last_digit;
          if (item_q.last_digit) begin
            cursor_d        = '0;
            res_o.word_done = 1'b1;
          end else begin
            cursor_d   = nxt_q;
            cur_mask_d = '0;
            cur_end_d  = 1'b0;
          end
          res_o.conflict = conflict_d;
          res_o.overflow = overflow_d;
        end
      end

      default: begin
        res_load_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpcd_pkg::ST_IDLE;
      cursor_q    <= '0;
      root_mask_q <= '0;
      nfree_q     <= tpcd_pkg::FREE_W'(1);
      conflict_q  <= 1'b0;
      overflow_q  <= 1'b0;
      skip_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      root_mask_q <= root_mask_d;
      nfree_q     <= nfree_d;
      conflict_q  <= conflict_d;
      overflow_q  <= overflow_d;
      skip_q      <= skip_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    slot_q     <= slot_d;
    nxt_q      <= nxt_d;
    cur_mask_q <= cur_mask_d;
    cur_end_q  <= cur_end_d;
  end

endmodule

// ----- rtl/core/trie_prefix_conflict_detector.sv -----
// trie_prefix_conflict_detector: top level with the two trie memories, the
// walker and the result register. Depends on tpcd_pkg, tpcd_in_if,
// tpcd_out_if, tpcd_ram and tpcd_walker.
//
// Usage:
//   req_i carries one request: cmd (insert a digit / clear), digit and
//   last_digit. Words are sent one digit per request, the final digit with
//   last_digit set. A clear empties the trie and both sticky flags.
//   rsp_o returns one result per request: the sticky conflict and overflow
//   flags after that request and word_done for a finished word.
// Requests: one at a time. A clear, an ignored digit (above nine),
//   a dropped digit or a digit that finds the pool full ends in the look
//   step; a digit that walks or allocates a node goes through the look step,
//   which reads the child slot of the current node, and then a step that
//   reads or initializes the next node entry. The next request is taken the
//   cycle after the result is registered.
// Result: loaded into the result register by the request's last step.
// Stall: a one-entry result register holds the result until rsp_o.ready;
//   while it is full the walker can still take one more request, then holds
//   its final step until the register frees.
// Reset: the trie is empty and ready at once; the node pool needs no
//   clearing pass, nodes are cleared as they are allocated.

module trie_prefix_conflict_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpcd_in_if.sink     req_i,
  tpcd_out_if.source  rsp_o
);

  tpcd_pkg::item_t                in_item;
  tpcd_pkg::child_req_t           child_req;
  tpcd_pkg::node_req_t            node_req;
  logic [tpcd_pkg::NODE_W-1:0]    child_rd_data;
  tpcd_pkg::node_t                node_rd_data;
  logic                           res_free;
  logic                           res_load;
  tpcd_pkg::res_t                 res;
  logic                           out_valid_q, out_valid_d;
  tpcd_pkg::res_t                 out_res_q, out_res_d;

  // request payload
  assign in_item.cmd        = req_i.cmd;
  assign in_item.digit      = req_i.digit;
  assign in_item.last_digit = req_i.last_digit;

  tpcd_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .in_item_i       (in_item),
    .child_req_o     (child_req),
    .child_rd_data_i (child_rd_data),
    .node_req_o      (node_req),
    .node_rd_data_i  (node_rd_data),
    .res_free_i      (res_free),
    .res_load_o      (res_load),
    .res_o           (res)
  );

  // child slot memory: one node number per (node, digit)
  tpcd_ram #(
    .WIDTH (tpcd_pkg::NODE_W),
    .DEPTH (tpcd_pkg::SLOT_COUNT)
  ) u_child_ram (
    .clk_i     (clk_i),
    .wr_en_i   (child_req.wr_en),
    .wr_addr_i (child_req.wr_addr),
    .wr_data_i (child_req.wr_data),
    .rd_en_i   (child_req.rd_en),
    .rd_addr_i (child_req.rd_addr),
    .rd_data_o (child_rd_data)
  );

  // node memory: child mask and end mark per node
  tpcd_ram #(
    .WIDTH ($bits(tpcd_pkg::node_t)),
    .DEPTH (tpcd_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk_i     (clk_i),
    .wr_en_i   (node_req.wr_en),
    .wr_addr_i (node_req.wr_addr),
    .wr_data_i (node_req.wr_data),
    .rd_en_i   (node_req.rd_en),
    .rd_addr_i (node_req.rd_addr),
    .rd_data_o (node_rd_data)
  );

  // result register
  assign res_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.conflict  = out_res_q.conflict;
  assign rsp_o.overflow  = out_res_q.overflow;
  assign rsp_o.word_done = out_res_q.word_done;

  // one request in flight: no request taken right after another
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted in two consecutive cycles");

  // a result is only loaded into a free result register
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> res_free)
    else $error("result loaded over an untaken result");

  // the root lives in flip-flops, never in the node memory
  a_no_root_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_req.wr_en |-> (node_req.wr_addr != '0))
    else $error("node memory write to the root entry");

endmodule

// ----- tb/tpcd_trie_checker.sv -----
// tpcd_trie_checker: watches the request and result channels of the trie prefix
// conflict detector, predicts each result and compares it. Depends on tpcd_pkg,
// tpcd_in_if and tpcd_out_if.

module tpcd_trie_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpcd_in_if          req_i,
  tpcd_out_if         rsp_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tpcd_pkg::*;

  // predicted trie: child slots, per-node child mask and word end
  logic [NODE_W-1:0] kid_node [SLOT_COUNT];
  logic [FANOUT-1:0] kid_mask [NODE_COUNT];
  logic              word_end [NODE_COUNT];
  logic [NODE_W-1:0] walk_node;
  logic [FREE_W-1:0] free_node;
  logic              conflict_seen;
  logic              pool_full_seen;
  logic              dropping_word;

  // flag results still owed by the block, oldest first
  res_t        due_flags [$];
  int unsigned fail_n = 0;
  int unsigned result_n = 0;

  // empty pool: root cleared, walk back at the root, flags down
  function automatic void empty_trie();
    kid_mask[0]    = '0;
    word_end[0]    = 1'b0;
    walk_node      = '0;
    free_node      = 1;
    conflict_seen  = 1'b0;
    pool_full_seen = 1'b0;
    dropping_word  = 1'b0;
  endfunction

  // one request through the predicted trie, returns the flags it leaves
  function automatic res_t trie_insert(logic cmd, logic [DIGIT_W-1:0] digit, logic last);
    logic [NODE_W-1:0] nxt;
    logic              have;
    logic              done;
    int unsigned       slot;
    res_t              r;
    nxt  = '0;
    have = 1'b1;
    done = 1'b0;
    if (cmd == CMD_CLEAR) begin
      empty_trie();
    end else if (digit < FANOUT) begin
      if (dropping_word) begin
        // rest of an overflowed word: only its end matters
        if (last) begin
          dropping_word = 1'b0;
          walk_node     = '0;
          done          = 1'b1;
        end
      end else begin
        slot = walk_node * FANOUT + digit;
        if (kid_mask[walk_node][digit]) begin
          nxt = kid_node[slot];
        end else if (free_node < NODE_COUNT) begin
          nxt = free_node[NODE_W-1:0];
          free_node = free_node + 1'b1;
          kid_mask[nxt] = '0;
          word_end[nxt] = 1'b0;
          kid_mask[walk_node][digit] = 1'b1;
          kid_node[slot] = nxt;
        end else begin
          have = 1'b0;
          pool_full_seen = 1'b1;
        end
        if (have) begin
          // walking through an earlier word end, or ending above a longer word
          if (word_end[nxt]) conflict_seen = 1'b1;
          walk_node = nxt;
          if (last) begin
            if (kid_mask[nxt] != '0) conflict_seen = 1'b1;
            word_end[nxt] = 1'b1;
            walk_node     = '0;
            done          = 1'b1;
          end
        end else if (last) begin
          walk_node = '0;
          done      = 1'b1;
        end else begin
          dropping_word = 1'b1;
        end
      end
    end
    r.conflict  = conflict_seen;
    r.overflow  = pool_full_seen;
    r.word_done = done;
    return r;
  endfunction

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      empty_trie();
      due_flags.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        due_flags.push_back(trie_insert(req_i.cmd, req_i.digit, req_i.last_digit));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.conflict  = rsp_i.conflict;
        got.overflow  = rsp_i.overflow;
        got.word_done = rsp_i.word_done;
        result_n++;
        if (due_flags.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%0t: result %0d with no request pending: conflict=%b overflow=%b word_done=%b",
                     $realtime, result_n, got.conflict, got.overflow, got.word_done);
        end else begin
          want = due_flags.pop_front();
          if (got.conflict !== want.conflict || got.overflow !== want.overflow ||
              got.word_done !== want.word_done) begin
            fail_n++;
            if (fail_n <= 10)
              $display("%0t: result %0d expected conflict=%b overflow=%b word_done=%b, got %b %b %b",
                       $realtime, result_n, want.conflict, want.overflow, want.word_done,
                       got.conflict, got.overflow, got.word_done);
          end
        end
      end
    end
    pending_o    <= due_flags.size();
    fail_count_o <= fail_n;
  end

endmodule

// ----- tb/tb.sv -----
// tb: top of the trie prefix conflict detector testbench; drives requests and
// result back-pressure and gives the verdict. Depends on tpcd_pkg, the two
// channel interfaces, trie_prefix_conflict_detector and tpcd_trie_checker.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpcd_pkg::*;

  typedef enum int {
    RX_OPEN,
    RX_RHYTHM,
    RX_COIN,
    RX_SLOW
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned pending;
  int unsigned fail_count;

  // sender burst state and request counts
  int unsigned burst_left;
  int unsigned live_sent;
  int          kept_word [$];
  int          cur_word [$];

  tpcd_in_if  req_if ();
  tpcd_out_if rsp_if ();

  trie_prefix_conflict_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  tpcd_trie_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 0;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result back-pressure, switching between stall patterns
  initial begin : rx_stall
    rx_mode_e    mode;
    int unsigned mode_left;
    mode      = RX_OPEN;
    mode_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (mode)
        RX_OPEN:   rsp_if.ready <= 1'b1;
        RX_RHYTHM: rsp_if.ready <= (mode_left % 3) != 0;
        RX_COIN:   rsp_if.ready <= $urandom_range(0, 1);
        default:   rsp_if.ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  // one request, held until taken, then maybe a gap between bursts
  task automatic send_req(input logic cmd, input logic [DIGIT_W-1:0] digit, input logic last);
    int unsigned gap;
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd;
    req_if.digit      <= digit;
    req_if.last_digit <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (!(cmd == CMD_INSERT && digit >= FANOUT)) live_sent++;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_clear();
    send_req(CMD_CLEAR, DIGIT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // whole word given as a string of decimal digits
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_req(CMD_INSERT, DIGIT_W'(s[i] - 8'd48), i == s.len() - 1);
  endtask

  // random word over the first alpha digits; noisy words carry ignored
  // digits and may be cut short by a clear
  task automatic send_rand_word(input int len, input int alpha, input bit noisy);
    int d;
    cur_word.delete();
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_req(CMD_INSERT, DIGIT_W'($urandom_range(10, 15)), 1'($urandom_range(0, 1)));
      if (noisy && $urandom_range(0, 39) == 0) begin
        send_clear();
        return;
      end
      d = $urandom_range(0, alpha - 1);
      cur_word.push_back(d);
      send_req(CMD_INSERT, DIGIT_W'(d), i == len - 1);
    end
  endtask

  task automatic replay_kept();
    foreach (kept_word[i])
      send_req(CMD_INSERT, DIGIT_W'(kept_word[i]), i == kept_word.size() - 1);
  endtask

  // stimulus
  initial begin
    int unsigned pick;
    int unsigned filled;
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_INSERT;
    req_if.digit      = '0;
    req_if.last_digit = 1'b0;
    burst_left = 0;
    live_sent  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clear, both prefix orders, repeats, ignored digits,
    // clear in mid-word, extreme digits
    send_req(CMD_CLEAR, 4'hF, 1'b1);
    send_text("12");
    send_text("1234");
    send_req(CMD_CLEAR, 4'h0, 1'b0);
    send_text("5678");
    send_text("56");
    send_clear();
    send_text("9");
    send_text("9");
    send_clear();
    send_req(CMD_INSERT, 4'hA, 1'b1);
    send_req(CMD_INSERT, 4'hF, 1'b0);
    send_text("09");
    send_req(CMD_INSERT, 4'h3, 1'b0);
    send_clear();
    send_text("3");

    // random words over small alphabets, clears between groups, some noise
    while (live_sent < 2000) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        send_clear();
      else if (pick < 12)
        send_req(CMD_INSERT, DIGIT_W'($urandom_range(10, 15)), 1'($urandom_range(0, 1)));
      else
        send_rand_word(($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6),
                       $urandom_range(2, 10), $urandom_range(0, 3) == 0);
    end

    // exhaust the node pool with long words, keeping the first one
    send_clear();
    filled = 0;
    while (filled < 4400) begin
      pick = $urandom_range(150, 250);
      send_rand_word(pick, 10, 1'b0);
      if (kept_word.size() == 0) kept_word = cur_word;
      filled += pick;
    end

    // full pool: known words still walk, new ones are dropped
    repeat (30) begin
      if ($urandom_range(0, 2) == 0)
        replay_kept();
      else
        send_rand_word($urandom_range(1, 20), 10, 1'b1);
    end

    // recovery after a clear
    send_clear();
    repeat (20) send_rand_word($urandom_range(1, 5), $urandom_range(2, 10), 1'b0);
    req_if.valid <= 1'b0;

    // drain, then allow for a stray late result
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tpcd_pkg.sv
rtl/core/tpcd_in_if.sv
rtl/core/tpcd_out_if.sv
rtl/core/tpcd_ram.sv
rtl/core/tpcd_walker.sv
rtl/core/trie_prefix_conflict_detector.sv
tb/tpcd_trie_checker.sv
tb/tb.sv
